@@ rtl/cstt_pkg.sv @@
`default_nettype none
package cstt_pkg;

  localparam int unsigned DivStages  = 64;
  localparam int unsigned FracBits   = 30;
  localparam int unsigned FracStages = 2 * FracBits;
  localparam int unsigned NumStages  = DivStages + FracStages;

  localparam logic [FracBits-1:0] NsPerSec = 30'd1000000000;
  localparam logic [63:0]         WholeMax = 64'd18446744073;

  typedef struct packed {
    logic [63:0]         n;
    logic [63:0]         d;
    logic [63:0]         r;
    logic [63:0]         q;
    logic [63:0]         rem;
    logic [63:0]         fr;
    logic [FracBits-1:0] fq;
    logic [63:0]         lat;
    logic                zero;
  } pipe_t;

  function automatic pipe_t div_step(input pipe_t p);
    pipe_t       o;
    logic [64:0] r2;
    logic        ge;
    o  = p;
    r2 = {p.r, p.n[63]};
    ge = r2 >= {1'b0, p.d};
    o.r   = ge ? 64'(r2 - {1'b0, p.d}) : r2[63:0];
    o.q   = {p.q[62:0], ge};
    o.n   = {p.n[62:0], 1'b0};
    o.rem = o.r;
    return o;
  endfunction

  function automatic pipe_t dbl_step(input pipe_t p);
    pipe_t       o;
    logic [64:0] r2;
    logic        ge;
    o  = p;
    r2 = {p.fr, 1'b0};
    ge = r2 >= {1'b0, p.d};
    o.fr = ge ? 64'(r2 - {1'b0, p.d}) : r2[63:0];
    o.fq = {p.fq[FracBits-2:0], ge};
    return o;
  endfunction

  function automatic pipe_t add_step(input pipe_t p);
    pipe_t       o;
    logic [64:0] s;
    logic        ge;
    o  = p;
    s  = {1'b0, p.fr} + {1'b0, p.rem};
    ge = s >= {1'b0, p.d};
    o.fr = ge ? 64'(s - {1'b0, p.d}) : s[63:0];
    o.fq = p.fq + FracBits'(ge);
    return o;
  endfunction

endpackage
`default_nettype wire

@@ rtl/cstt_tail.sv @@
`default_nettype none
module cstt_tail (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  wire cstt_pkg::pipe_t p_i,
  output logic                valid_o,
  output logic [63:0]         dur_o,
  output logic                failed_o
);
  import cstt_pkg::*;

  logic [2:0]  vld_q;
  logic [61:0] plo_q;
  logic [31:0] phi_q;
  logic        big_q, bad1_q, bad2_q, bad3_q;
  logic [FracBits:0] qf1_q, qf2_q;
  logic [63:0] lat1_q, lat2_q, lat3_q;
  logic [63:0] t_q;
  logic [64:0] s_q;
  logic [64:0] s2;
  logic        fail;
  logic [63:0] dur_q;
  logic        failed_q, out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q     <= {vld_q[1:0], valid_i};
      out_vld_q <= vld_q[2];
    end
  end

  assign s2   = {1'b0, s_q[63:0]} + {1'b0, lat3_q};
  assign fail = bad3_q | s_q[64] | s2[64];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      plo_q  <= 62'(p_i.q[31:0]) * 62'(NsPerSec);
      phi_q  <= 32'(p_i.q[34:32]) * 32'(NsPerSec);
      big_q  <= p_i.q > WholeMax;
      bad1_q <= p_i.zero;
      qf1_q  <= {1'b0, p_i.fq} + (FracBits+1)'(p_i.fr != '0);
      lat1_q <= p_i.lat;

      t_q    <= {2'b0, plo_q} + {phi_q, 32'b0};
      bad2_q <= bad1_q | big_q;
      qf2_q  <= qf1_q;
      lat2_q <= lat1_q;

      s_q    <= {1'b0, t_q} + 65'(qf2_q);
      bad3_q <= bad2_q;
      lat3_q <= lat2_q;

      dur_q    <= fail ? '0 : s2[63:0];
      failed_q <= fail;
    end
  end

  assign valid_o  = out_vld_q;
  assign dur_o    = dur_q;
  assign failed_o = failed_q;
endmodule
`default_nettype wire

@@ rtl/ceil_scaled_transfer_time_unit.sv @@
`default_nettype none
// channel  | dir | tdata                                     | tuser
// s_axis   | in  | size_bytes[63:0] bandwidth_bps[127:64]     | -
//          |     | fixed_delay[191:128]                      |
// m_axis   | out | duration_ns[63:0]                         | failed
//
// One request per cycle unless the output stalls; 64 restoring divide stages,
// 60 fraction stages (double and add per bit of 1e9), 4 scale/add stages.
// Reset clears valid bits only.
// The whole pipeline holds while the output register is full and not taken.
module ceil_scaled_transfer_time_unit (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [191:0] s_axis_tdata,  // size_bytes, bandwidth_bps, fixed_delay
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [63:0]       m_axis_tdata,  // duration_ns
  output logic              m_axis_tuser   // failed
);
  import cstt_pkg::*;

  logic                 en;
  logic [NumStages-1:0] vld_q;
  pipe_t                pipe_q [NumStages];
  pipe_t                pipe_d [NumStages];
  pipe_t                head;

  assign en            = ~m_axis_tvalid | m_axis_tready;
  assign s_axis_tready = en;

  always_comb begin
    head      = '0;
    head.n    = s_axis_tdata[63:0];
    head.d    = s_axis_tdata[127:64];
    head.lat  = s_axis_tdata[191:128];
    head.zero = s_axis_tdata[127:64] == '0;
  end

  for (genvar k = 0; k < NumStages; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign pipe_d[k] = div_step(head);
    end else if (k < DivStages) begin : g_div
      assign pipe_d[k] = div_step(pipe_q[k-1]);
    end else if (((k - DivStages) % 2) == 0) begin : g_dbl
      assign pipe_d[k] = dbl_step(pipe_q[k-1]);
    end else if (NsPerSec[FracBits - 1 - (k - DivStages) / 2]) begin : g_add
      assign pipe_d[k] = add_step(pipe_q[k-1]);
    end else begin : g_pass
      assign pipe_d[k] = pipe_q[k-1];
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        pipe_q[k] <= pipe_d[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NumStages-2:0], s_axis_tvalid};
    end
  end

  cstt_tail u_tail (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (vld_q[NumStages-1]),
    .p_i      (pipe_q[NumStages-1]),
    .valid_o  (m_axis_tvalid),
    .dur_o    (m_axis_tdata),
    .failed_o (m_axis_tuser)
  );

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("failed result carries nonzero duration");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved during stall");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("request taken while output blocked");
endmodule
`default_nettype wire
